/* rtl/signed_decimal_text_parser_defines.svh */
// Assertion macros used by the checker file of the decimal text parser.
`ifndef SIGNED_DECIMAL_TEXT_PARSER_DEFINES_SVH
`define SIGNED_DECIMAL_TEXT_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SDTP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SDTP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sdtp_pkg.sv */
// Types and character constants of the decimal text parser.
`timescale 1ns / 1ps

package sdtp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 32;

  localparam logic [ByteW-1:0] CharSpace = 8'h20;
  localparam logic [ByteW-1:0] CharMinus = 8'h2D;
  localparam logic [ByteW-1:0] CharZero  = 8'h30;
  localparam logic [ByteW-1:0] DigitMax  = 8'd9;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_SYNTAX = 2'd2
  } status_e;

  typedef struct packed {
    status_e                  status;
    logic signed [ValueW-1:0] value;
  } result_t;

endpackage

/* rtl/sdtp_in_if.sv */
// Input channel: one ASCII byte per word.
`timescale 1ns / 1ps

interface sdtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

/* rtl/sdtp_out_if.sv */
// Output channel: one parse result per word.
`timescale 1ns / 1ps

interface sdtp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] value;

  modport source (output valid, output status, output value, input ready);
  modport sink   (input valid, input status, input value, output ready);
endinterface

/* rtl/sdtp_in_stage.sv */
// Input register of the parser: holds one byte until the core takes it.
`timescale 1ns / 1ps

module sdtp_in_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  sdtp_in_if.sink                     in_i,
  input  logic                        adv_i,
  output logic                        vld_o,
  output logic [sdtp_pkg::ByteW-1:0]  byte_o
);

  logic                       vld_q, vld_d;
  logic [sdtp_pkg::ByteW-1:0] byte_q;
  logic                       take;

  // Accept a word whenever the register is empty or drains this cycle
  assign in_i.ready = !vld_q || adv_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (adv_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Capture payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= in_i.in_byte;
    end
  end

  assign vld_o  = vld_q;
  assign byte_o = byte_q;

endmodule

/* rtl/sdtp_core.sv */
// Parser state and per-byte decode: accumulate digits, emit a result on end.
`timescale 1ns / 1ps

module sdtp_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [sdtp_pkg::ByteW-1:0]  byte_i,
  output logic                        emit_o,
  output sdtp_pkg::result_t           res_o
);

  logic                        in_number_q, in_number_d;
  logic                        negative_q, negative_d;
  logic [sdtp_pkg::ValueW-1:0] acc_q, acc_d;

  logic [sdtp_pkg::ByteW-1:0]  digit;
  logic                        is_digit;
  logic [sdtp_pkg::ValueW-1:0] acc_x10;
  logic [sdtp_pkg::ValueW-1:0] magnitude;
  logic                        emit;
  sdtp_pkg::result_t           res;

  // Decode digit; times ten as shift-add, wrapping at 32 bits
  assign digit    = byte_i - sdtp_pkg::CharZero;
  assign is_digit = (digit <= sdtp_pkg::DigitMax);
  assign acc_x10  = {acc_q[sdtp_pkg::ValueW-4:0], 3'b000}
                  + {acc_q[sdtp_pkg::ValueW-2:0], 1'b0}
                  + {{(sdtp_pkg::ValueW-sdtp_pkg::ByteW){1'b0}}, digit};
  assign magnitude = negative_q ? (sdtp_pkg::ValueW'(0) - acc_q) : acc_q;

  // Next state and result for the byte in the input register
  always_comb begin
    in_number_d = in_number_q;
    negative_d  = negative_q;
    acc_d       = acc_q;
    emit        = 1'b0;
    res.status  = sdtp_pkg::ST_OK;
    res.value   = '0;
    if (!in_number_q) begin
      if (byte_i < sdtp_pkg::CharSpace) begin
        emit       = 1'b1;
        res.status = sdtp_pkg::ST_EMPTY;
      end else if (byte_i == sdtp_pkg::CharSpace) begin
        // skip leading space
      end else if (byte_i == sdtp_pkg::CharMinus) begin
        negative_d  = 1'b1;
        in_number_d = 1'b1;
      end else if (!is_digit) begin
        emit       = 1'b1;
        res.status = sdtp_pkg::ST_SYNTAX;
      end else begin
        acc_d       = {{(sdtp_pkg::ValueW-sdtp_pkg::ByteW){1'b0}}, digit};
        in_number_d = 1'b1;
      end
    end else begin
      if (byte_i <= sdtp_pkg::CharSpace) begin
        emit       = 1'b1;
        res.status = sdtp_pkg::ST_OK;
        res.value  = magnitude;
      end else if (!is_digit) begin
        emit       = 1'b1;
        res.status = sdtp_pkg::ST_SYNTAX;
      end else begin
        acc_d = acc_x10;
      end
    end
    // Return to start after every result
    if (emit) begin
      in_number_d = 1'b0;
      negative_d  = 1'b0;
      acc_d       = '0;
    end
  end

  // Advance state only on a processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_number_q <= 1'b0;
      negative_q  <= 1'b0;
      acc_q       <= '0;
    end else if (step_i) begin
      in_number_q <= in_number_d;
      negative_q  <= negative_d;
      acc_q       <= acc_d;
    end
  end

  assign emit_o = step_i && emit;
  assign res_o  = res;

endmodule

/* rtl/sdtp_out_stage.sv */
// Result register of the parser: holds a word until the receiver takes it.
`timescale 1ns / 1ps

module sdtp_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  sdtp_pkg::result_t res_i,
  output logic              stall_o,
  sdtp_out_if.source        out_o
);

  logic              vld_q, vld_d;
  sdtp_pkg::result_t res_q;

  // Set on load, drop once the receiver takes the word
  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (out_o.ready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign stall_o      = vld_q && !out_o.ready;
  assign out_o.valid  = vld_q;
  assign out_o.status = res_q.status;
  assign out_o.value  = res_q.value;

endmodule

/* rtl/signed_decimal_text_parser.sv */
// Top level of the signed decimal text parser.
//
// Input channel in_i carries one ASCII byte per word; output channel out_o
// carries a status (ok, empty line, syntax error) and a 32-bit signed value.
// Leading spaces are skipped, an optional minus may precede the digits, and
// any byte at or below space after the number starts ends it. A control
// byte before the number reports an empty line; other non-digits report a
// syntax error. The ending or bad byte is consumed.
//
// Throughput is one byte per cycle while the receiver does not stall. A
// byte is held in the input register, decoded against the parser state,
// and its result (if any) is loaded into the result register, which drives
// out_o. The times-ten shift-add feeding the accumulator sets the critical
// path.
// Reset clears the parser state and both valid flags. When the receiver
// stalls, the result word holds and the input register fills; in_i.ready
// then drops until the result word is taken.
`timescale 1ns / 1ps

module signed_decimal_text_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  sdtp_in_if.sink    in_i,
  sdtp_out_if.source out_o
);

  logic                       in_vld;
  logic [sdtp_pkg::ByteW-1:0] in_byte;
  logic                       out_stall;
  logic                       step;
  logic                       emit;
  sdtp_pkg::result_t          res;

  // Process the held byte unless the result word is stalled
  assign step = in_vld && !out_stall;

  sdtp_in_stage u_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .adv_i  (step),
    .vld_o  (in_vld),
    .byte_o (in_byte)
  );

  sdtp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte),
    .emit_o (emit),
    .res_o  (res)
  );

  sdtp_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (emit),
    .res_i   (res),
    .stall_o (out_stall),
    .out_o   (out_o)
  );

endmodule

/* rtl/sdtp_checker.sv */
// Port-level checks of the decimal text parser, bound to the top level.
`timescale 1ns / 1ps
`include "signed_decimal_text_parser_defines.svh"

module sdtp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_status_i,
  input logic [31:0] out_value_i
);

  `SDTP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_status_i) && $stable(out_value_i), "stalled result word changed")

  `SDTP_ASSERT_NOW(a_status_code, clk_i, rst_ni, out_valid_i, out_status_i == sdtp_pkg::ST_OK || out_status_i == sdtp_pkg::ST_EMPTY || out_status_i == sdtp_pkg::ST_SYNTAX, "undefined status code")

  `SDTP_ASSERT_NOW(a_value_zero, clk_i, rst_ni, out_valid_i && out_status_i != sdtp_pkg::ST_OK, out_value_i == 32'd0, "nonzero value on a failed parse")

  `SDTP_ASSERT_NOW(a_result_cause, clk_i, rst_ni, $rose(out_valid_i), $past(in_valid_i && in_ready_i, 2), "result without a byte two cycles earlier")

endmodule

bind signed_decimal_text_parser sdtp_checker u_sdtp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_value_i  (out_o.value)
);

/* verif/signed_decimal_text_parser_tb.sv */
// Testbench for the signed decimal text parser: byte stream stimulus and result scoreboard.
`timescale 1ns / 1ps

module signed_decimal_text_parser_tb;

  localparam int unsigned ClkPeriod   = 12;
  localparam int unsigned ResetCycles = 8;
  localparam int unsigned RandomBytes = 1350;
  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned HoldCycles  = 120;
  localparam int unsigned HoldAfter   = 400;
  localparam logic [31:0] Radix       = 32'd10;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Source and sink side drive registers, known from time zero.
  logic       src_valid = 1'b0;
  logic [7:0] src_byte  = 8'h00;
  logic       snk_ready = 1'b0;

  sdtp_in_if  in_ch ();
  sdtp_out_if out_ch ();

  assign in_ch.valid   = src_valid;
  assign in_ch.in_byte = src_byte;
  assign out_ch.ready  = snk_ready;

  signed_decimal_text_parser dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  // Text stream to send and parse results still owed by the block.
  logic [7:0]          text_bytes[$];
  sdtp_pkg::result_t   parse_results[$];

  // Shadow parser state.
  logic        num_started = 1'b0;
  logic        minus_seen  = 1'b0;
  logic [31:0] magnitude   = 32'd0;

  int unsigned n_bytes_in  = 0;
  int unsigned offer_idx   = 0;
  int unsigned src_gap     = 0;
  int unsigned src_burst   = 0;
  int unsigned snk_stall   = 0;
  int unsigned snk_burst   = 0;
  int unsigned idle_cycles = 0;
  int unsigned fail_count  = 0;
  int unsigned n_ok        = 0;
  int unsigned n_empty     = 0;
  int unsigned n_syntax    = 0;
  logic        hold_off    = 1'b0;

  always #(ClkPeriod / 2) clk = ~clk;

  // Pick an idle length: mostly short, a few long, with stretches of none.
  function automatic int unsigned draw_gap(inout int unsigned burst);
    int unsigned roll;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Record one expected result and return the shadow parser to its start.
  task automatic queue_result(input sdtp_pkg::status_e st, input logic [31:0] val);
    sdtp_pkg::result_t r;
    r.status = st;
    r.value  = val;
    parse_results.push_back(r);
    num_started = 1'b0;
    minus_seen  = 1'b0;
    magnitude   = 32'd0;
  endtask

  // Advance the shadow parser by one accepted byte.
  task automatic parse_byte(input logic [7:0] b);
    logic [7:0] dgt;
    logic       is_dgt;
    dgt    = b - sdtp_pkg::CharZero;
    is_dgt = (dgt <= sdtp_pkg::DigitMax);
    if (!num_started) begin
      if (b < sdtp_pkg::CharSpace) queue_result(sdtp_pkg::ST_EMPTY, 32'd0);
      else if (b == sdtp_pkg::CharSpace) begin
        // skip leading space
      end else if (b == sdtp_pkg::CharMinus) begin
        minus_seen  = 1'b1;
        num_started = 1'b1;
      end else if (!is_dgt) queue_result(sdtp_pkg::ST_SYNTAX, 32'd0);
      else begin
        magnitude   = {24'd0, dgt};
        num_started = 1'b1;
      end
    end else if (b <= sdtp_pkg::CharSpace) begin
      queue_result(sdtp_pkg::ST_OK, minus_seen ? (32'd0 - magnitude) : magnitude);
    end else if (!is_dgt) begin
      queue_result(sdtp_pkg::ST_SYNTAX, 32'd0);
    end else begin
      magnitude = magnitude * Radix + {24'd0, dgt};
    end
  endtask

  // Pick a byte above space that is not a digit; a quarter of the time it is the minus sign.
  function automatic logic [7:0] bad_byte();
    logic [7:0] b;
    if ($urandom_range(0, 3) == 0) return sdtp_pkg::CharMinus;
    b = 8'($urandom_range(8'h21, 8'hFF));
    while (b >= sdtp_pkg::CharZero && b <= sdtp_pkg::CharZero + sdtp_pkg::DigitMax) begin
      b = 8'($urandom_range(8'h21, 8'hFF));
    end
    return b;
  endfunction

  // Sender: offer the next byte once the current one is taken.
  always @(negedge clk) begin
    logic       nxt_valid;
    logic [7:0] nxt_byte;
    nxt_valid = src_valid;
    nxt_byte  = src_byte;
    if (rst_n && (!src_valid || n_bytes_in > offer_idx)) begin
      if (src_gap > 0) begin
        src_gap--;
        nxt_valid = 1'b0;
      end else if (n_bytes_in < text_bytes.size()) begin
        nxt_valid = 1'b1;
        nxt_byte  = text_bytes[n_bytes_in];
        offer_idx = n_bytes_in;
        src_gap   = draw_gap(src_burst);
      end else begin
        nxt_valid = 1'b0;
      end
    end
    src_valid <= nxt_valid;
    src_byte  <= nxt_byte;
  end

  // Receiver: stall at random, and hold off entirely while asked to.
  always @(negedge clk) begin
    logic nxt_ready;
    nxt_ready = 1'b0;
    if (rst_n && !hold_off) begin
      if (snk_stall > 0) snk_stall--;
      else begin
        nxt_ready = 1'b1;
        snk_stall = draw_gap(snk_burst);
      end
    end
    snk_ready <= nxt_ready;
  end

  // Long receiver hold-off while the sender keeps offering, to fill the block.
  initial begin
    while (n_bytes_in < HoldAfter) @(posedge clk);
    hold_off = 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_off = 1'b0;
  end

  // Sample both channels: predict on each input word, check each result word.
  always @(posedge clk) begin
    sdtp_pkg::result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        parse_byte(in_ch.in_byte);
        n_bytes_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (parse_results.size() == 0) begin
          $error("unexpected result word: status %0d value %0d", out_ch.status, out_ch.value);
          fail_count++;
        end else begin
          want = parse_results.pop_front();
          case (want.status)
            sdtp_pkg::ST_OK:    n_ok++;
            sdtp_pkg::ST_EMPTY: n_empty++;
            default:            n_syntax++;
          endcase
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            fail_count++;
          end
          if (out_ch.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, out_ch.value);
            fail_count++;
          end
        end
      end
      // Watchdog on cycles with no word moving on either channel.
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Build the text stream, release reset, and wait for the block to drain.
  initial begin
    int unsigned n_counted;
    int unsigned kind;
    int unsigned len;

    // Control bytes before a number: empty line.
    text_bytes.push_back(8'h00);
    text_bytes.push_back(8'h1F);
    // Minus alone, ended by a newline.
    text_bytes.push_back(sdtp_pkg::CharSpace);
    text_bytes.push_back(sdtp_pkg::CharMinus);
    text_bytes.push_back(8'h0A);
    // Second minus.
    text_bytes.push_back(sdtp_pkg::CharMinus);
    text_bytes.push_back(sdtp_pkg::CharMinus);
    // Top half of the byte range.
    text_bytes.push_back(8'hFF);
    // Digit then a letter.
    text_bytes.push_back(sdtp_pkg::CharZero + 8'd5);
    text_bytes.push_back(8'h41);
    // Zero ended by a NUL.
    text_bytes.push_back(sdtp_pkg::CharZero);
    text_bytes.push_back(8'h00);
    // Ten nines, negated: wraps the accumulator.
    text_bytes.push_back(sdtp_pkg::CharMinus);
    repeat (10) text_bytes.push_back(sdtp_pkg::CharZero + sdtp_pkg::DigitMax);
    text_bytes.push_back(sdtp_pkg::CharSpace);

    n_counted = 0;
    while (n_counted < RandomBytes) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        // Number with random content; some are broken partway.
        repeat ($urandom_range(0, 2)) begin
          text_bytes.push_back(sdtp_pkg::CharSpace);
          n_counted++;
        end
        if ($urandom_range(0, 9) < 4) begin
          text_bytes.push_back(sdtp_pkg::CharMinus);
          n_counted++;
        end
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 6);
        repeat (len) begin
          text_bytes.push_back(sdtp_pkg::CharZero + 8'($urandom_range(0, 9)));
          n_counted++;
        end
        if (kind < 68) begin
          text_bytes.push_back(($urandom_range(0, 1) == 0) ? sdtp_pkg::CharSpace
                                                            : 8'($urandom_range(0, 32)));
        end else begin
          text_bytes.push_back(bad_byte());
        end
        n_counted++;
      end else if (kind < 90) begin
        text_bytes.push_back(8'($urandom_range(0, 31)));
        n_counted++;
      end else begin
        text_bytes.push_back(8'($urandom_range(0, 255)));
        n_counted++;
      end
    end

    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (n_bytes_in < text_bytes.size()) @(posedge clk);
    while (parse_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (parse_results.size() != 0) begin
      $error("%0d results never arrived", parse_results.size());
      fail_count++;
    end

    $display("Sent %0d bytes; checked %0d numbers, %0d empty lines, %0d syntax errors.",
             n_bytes_in, n_ok, n_empty, n_syntax);
    $display("Random idling on both sides, with one long receiver hold-off of %0d cycles.",
             HoldCycles);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
